[hdl/tpbc_pkg.sv]
// Shared types, codes and constants for the turn proximity buzzer controller.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tpbc_pkg;

    localparam int unsigned DIST_W  = 16;
    localparam int unsigned HASH_W  = 32;
    localparam int unsigned CUE_W   = 16;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Item kinds carried on the input side band.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Proximity state, held one-hot.
    typedef enum logic [5:0] {
        PROX_NONE     = 6'b000001,
        PROX_NEW      = 6'b000010,
        PROX_FAR      = 6'b000100,
        PROX_NEAR     = 6'b001000,
        PROX_IMMINENT = 6'b010000,
        PROX_AT       = 6'b100000
    } t_prox;

    // Encoded proximity state as reported on the result.
    localparam logic [CODE_W-1:0] CODE_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_NEW      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_FAR      = 3'd2;
    localparam logic [CODE_W-1:0] CODE_NEAR     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_IMMINENT = 3'd4;
    localparam logic [CODE_W-1:0] CODE_AT       = 3'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AT_LIMIT       = 3'd0,
        CFG_IMMINENT_LIMIT = 3'd1,
        CFG_NEAR_LIMIT     = 3'd2,
        CFG_SHORT_CUE      = 3'd3,
        CFG_MEDIUM_CUE     = 3'd4,
        CFG_LONG_CUE       = 3'd5
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] RST_AT_LIMIT       = 16'd10;
    localparam logic [CFG_DATA_W-1:0] RST_IMMINENT_LIMIT = 16'd20;
    localparam logic [CFG_DATA_W-1:0] RST_NEAR_LIMIT     = 16'd100;
    localparam logic [CFG_DATA_W-1:0] RST_SHORT_CUE      = 16'd100;
    localparam logic [CFG_DATA_W-1:0] RST_MEDIUM_CUE     = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_LONG_CUE       = 16'd400;

    // Turn icon hashes that have a cue pattern of their own.
    localparam logic [HASH_W-1:0] ICON_LEFT_ONLY   = 32'h27d9a40f;
    localparam logic [HASH_W-1:0] ICON_ROUTE_TGT   = 32'h09cefe42;
    localparam logic [HASH_W-1:0] ICON_BOTH_A      = 32'h3db5d6ba;
    localparam logic [HASH_W-1:0] ICON_BOTH_B      = 32'h28936c85;
    localparam logic [HASH_W-1:0] ICON_DEST        = 32'h9a84a956;

    typedef struct packed {
        logic [DIST_W-1:0] at_limit;
        logic [DIST_W-1:0] imminent_limit;
        logic [DIST_W-1:0] near_limit;
        logic [CUE_W-1:0]  short_cue_ms;
        logic [CUE_W-1:0]  medium_cue_ms;
        logic [CUE_W-1:0]  long_cue_ms;
    } t_cfg;

    typedef struct packed {
        t_prox             mode;
        logic [HASH_W-1:0] last_hash;
        logic [CUE_W-1:0]  cue_remaining;
        logic              left_drive;
        logic              right_drive;
    } t_state;

    function automatic logic [CODE_W-1:0] prox_code(input t_prox mode);
        logic [CODE_W-1:0] code;
        unique case (mode)
            PROX_NONE:     code = CODE_NONE;
            PROX_NEW:      code = CODE_NEW;
            PROX_FAR:      code = CODE_FAR;
            PROX_NEAR:     code = CODE_NEAR;
            PROX_IMMINENT: code = CODE_IMMINENT;
            PROX_AT:       code = CODE_AT;
            default:       code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hdl/tpbc_cfg.sv]
// Configuration register bank of the turn proximity buzzer controller.
// Depends on tpbc_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps
`default_nettype none

module tpbc_cfg
    import tpbc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_AT_LIMIT:       n_cfg.at_limit       = i_wr_data;
                CFG_IMMINENT_LIMIT: n_cfg.imminent_limit = i_wr_data;
                CFG_NEAR_LIMIT:     n_cfg.near_limit     = i_wr_data;
                CFG_SHORT_CUE:      n_cfg.short_cue_ms   = i_wr_data;
                CFG_MEDIUM_CUE:     n_cfg.medium_cue_ms  = i_wr_data;
                CFG_LONG_CUE:       n_cfg.long_cue_ms    = i_wr_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.at_limit       <= RST_AT_LIMIT;
            r_cfg.imminent_limit <= RST_IMMINENT_LIMIT;
            r_cfg.near_limit     <= RST_NEAR_LIMIT;
            r_cfg.short_cue_ms   <= RST_SHORT_CUE;
            r_cfg.medium_cue_ms  <= RST_MEDIUM_CUE;
            r_cfg.long_cue_ms    <= RST_LONG_CUE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hdl/tpbc_step.sv]
// Next-state logic for one item: proximity cascade, cue start and countdown.
// Depends on tpbc_pkg for t_state, t_cfg, t_prox and the icon hashes.
`timescale 1ns / 1ps
`default_nettype none

module tpbc_step
    import tpbc_pkg::*;
(
    input  wire t_state            i_cur,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_op,
    input  wire logic [HASH_W-1:0] i_hash,
    input  wire logic [DIST_W-1:0] i_dist,
    output t_state                 o_nxt,
    output logic                   o_started
);

    t_prox             dist_state;
    logic              go;
    logic              cue_left;
    logic              cue_right;
    logic [CUE_W-1:0]  cue_len;

    // State picked by distance; the reached test has priority.
    always_comb begin
        if (i_dist <= i_cfg.at_limit) begin
            dist_state = PROX_AT;
        end else if (i_dist < i_cfg.imminent_limit) begin
            dist_state = PROX_IMMINENT;
        end else if (i_dist < i_cfg.near_limit) begin
            dist_state = PROX_NEAR;
        end else begin
            dist_state = PROX_FAR;
        end
    end

    // Buzzer pattern and length by icon.
    always_comb begin
        cue_left  = 1'b1;
        cue_right = 1'b1;
        cue_len   = i_cfg.short_cue_ms;
        case (i_hash)
            ICON_LEFT_ONLY: cue_right = 1'b0;
            ICON_ROUTE_TGT: cue_len   = i_cfg.medium_cue_ms;
            ICON_BOTH_A, ICON_BOTH_B: cue_len = i_cfg.short_cue_ms;
            ICON_DEST:      cue_len   = i_cfg.long_cue_ms;
            default: begin
                cue_left  = 1'b0;
                cue_right = 1'b0;
            end
        endcase
        if (cue_len == '0) begin
            cue_len = CUE_W'(1);
        end
    end

    // The cascade always settles on the distance state when it moves at all:
    // none and at pass through new turn and far, so only the final entry matters.
    always_comb begin
        unique case (i_cur.mode) inside
            PROX_NEW:                          go = 1'b1;
            PROX_FAR, PROX_NEAR, PROX_IMMINENT: go = (dist_state != i_cur.mode);
            PROX_AT:                           go = (i_dist > i_cfg.at_limit);
            default:                           go = (i_hash != i_cur.last_hash);
        endcase
    end

    always_comb begin
        o_nxt     = i_cur;
        o_started = 1'b0;
        if (i_op == OP_UPDATE) begin
            if (go) begin
                o_nxt.mode = dist_state;
                if (dist_state != PROX_FAR) begin
                    o_started           = 1'b1;
                    o_nxt.left_drive    = cue_left;
                    o_nxt.right_drive   = cue_right;
                    o_nxt.cue_remaining = cue_len;
                end
            end else if (i_cur.mode != PROX_NEW && i_cur.mode != PROX_FAR &&
                         i_cur.mode != PROX_NEAR && i_cur.mode != PROX_IMMINENT &&
                         i_cur.mode != PROX_AT) begin
                // An unknown code falls back to none.
                o_nxt.mode = PROX_NONE;
            end
            o_nxt.last_hash = i_hash;
        end else if (i_cur.cue_remaining != '0) begin
            o_nxt.cue_remaining = i_cur.cue_remaining - CUE_W'(1);
            if (i_cur.cue_remaining == CUE_W'(1)) begin
                o_nxt.left_drive  = 1'b0;
                o_nxt.right_drive = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/turn_proximity_buzzer_controller.sv]
// Top level of the turn proximity buzzer controller: stream ports, input
// register, state and result register. Depends on tpbc_pkg, tpbc_cfg, tpbc_step.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                    | Contents
// ----------+-----------+------------------------------+-------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: icon_hash, distance; tuser: op
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: left_on, right_on,
//           |           |                              |   prox_state, cue_started
// cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Every item gives exactly one result item. An accepted item is held in the
// input register and passes through the step logic into the result register
// when that register is empty or its item is being taken. The step logic is a
// single short combinational pass, so one item is accepted in every cycle while
// results are being taken.
// When the result register is full and not taken, both stages hold and
// s_axis_tready falls only once the input register is occupied as well.
// The synchronous active-low reset clears the proximity state, the stored icon
// hash, the cue count, the buzzer drives and loads the register defaults.
// Configuration writes are always accepted and take effect on the next cycle.

module turn_proximity_buzzer_controller
    import tpbc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Bits 31:0 icon_hash, 47:32 distance.
    input  wire logic [47:0]           s_axis_tdata,
    // Bit 0 op.
    input  wire logic                  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Bit 0 left_on, 1 right_on, 4:2 prox_state, 5 cue_started, 7:6 zero.
    output logic [7:0]                 m_axis_tdata,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    logic              started;

    logic              r_in_valid;
    logic              r_op;
    logic [HASH_W-1:0] r_hash;
    logic [DIST_W-1:0] r_dist;

    logic              r_out_valid;
    logic [7:0]        r_out_data;

    logic              advance;
    logic              in_take;

    // The input register moves into the result register whenever the latter
    // is empty or its item is being taken in this cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    tpbc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    tpbc_step u_step (
        .i_cur     (r_state),
        .i_cfg     (cfg),
        .i_op      (r_op),
        .i_hash    (r_hash),
        .i_dist    (r_dist),
        .o_nxt     (n_state),
        .o_started (started)
    );

    // Input register; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= s_axis_tuser;
            r_hash <= s_axis_tdata[31:0];
            r_dist <= s_axis_tdata[47:32];
        end
    end

    // Block state advances once per item, in step with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= PROX_NONE;
            r_state.last_hash     <= '0;
            r_state.cue_remaining <= '0;
            r_state.left_drive    <= 1'b0;
            r_state.right_drive   <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {2'b00, started, prox_code(n_state.mode),
                           n_state.right_drive, n_state.left_drive};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[test/turn_proximity_buzzer_controller_tb.sv]
// Self-checking testbench for the turn proximity buzzer controller.
// Depends on tpbc_pkg and on the RTL of turn_proximity_buzzer_controller.
`timescale 1ns / 1ps

module turn_proximity_buzzer_controller_tb
    import tpbc_pkg::*;
();

    // Cycles without any input, result or register handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;

    // Register indexes beyond the last real register: writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // One navigation update or millisecond tick, as it travels on the input stream.
    typedef struct packed {
        logic              op;
        logic [HASH_W-1:0] hash;
        logic [DIST_W-1:0] metres;
    } t_nav_item;

    // One result item: buzzer drives, proximity code and the cue-start flag.
    typedef struct packed {
        logic              started;
        logic [CODE_W-1:0] prox;
        logic              right;
        logic              left;
    } t_buzz_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Items waiting to be driven, and results the predictor has worked out.
    t_nav_item  nav_pending[$];
    t_buzz_item buzz_expected[$];

    // Predictor copy of the registers and of the controller state.
    t_cfg              cfg_now;
    logic [CODE_W-1:0] mode_now;
    logic [HASH_W-1:0] hash_seen;
    logic [CUE_W-1:0]  cue_left;
    logic              buzz_l;
    logic              buzz_r;

    int   fail_count = 0;
    int   queued_count = 0;
    int   quiet_cycles = 0;
    int   idle_pct = 0;
    int   feed_gap = 0;
    int   sink_gap = 0;
    logic in_taken = 1'b0;

    turn_proximity_buzzer_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Proximity zone for a distance; the at test wins, then imminent, then near,
    // so that inconsistent thresholds resolve the same way as in the block.
    function automatic logic [CODE_W-1:0] zone_of(input logic [DIST_W-1:0] m);
        if (m <= cfg_now.at_limit) return CODE_AT;
        if (m < cfg_now.imminent_limit) return CODE_IMMINENT;
        if (m < cfg_now.near_limit) return CODE_NEAR;
        return CODE_FAR;
    endfunction

    // Moves to a new proximity state. Near, imminent and at start a fresh cue,
    // whose buzzers and length come from the icon; a zero length counts as 1 ms.
    task automatic enter_mode(input logic [CODE_W-1:0] nxt, input logic [HASH_W-1:0] icon,
                              inout logic fired);
        logic [CUE_W-1:0] span;
        mode_now = nxt;
        if (nxt == CODE_NEAR || nxt == CODE_IMMINENT || nxt == CODE_AT) begin
            span   = cfg_now.short_cue_ms;
            buzz_l = 1'b0;
            buzz_r = 1'b0;
            case (icon)
                ICON_LEFT_ONLY: begin
                    buzz_l = 1'b1;
                end
                ICON_ROUTE_TGT: begin
                    buzz_l = 1'b1;
                    buzz_r = 1'b1;
                    span   = cfg_now.medium_cue_ms;
                end
                ICON_BOTH_A, ICON_BOTH_B: begin
                    buzz_l = 1'b1;
                    buzz_r = 1'b1;
                end
                ICON_DEST: begin
                    buzz_l = 1'b1;
                    buzz_r = 1'b1;
                    span   = cfg_now.long_cue_ms;
                end
                default: begin
                    // Unknown icon: silent cue, but the countdown still runs.
                end
            endcase
            cue_left = (span == '0) ? 16'd1 : span;
            fired    = 1'b1;
        end
    endtask

    // Applies one accepted item to the predictor state and gives its result.
    task automatic advance_controller(input t_nav_item it, output t_buzz_item res);
        logic [CODE_W-1:0] was;
        logic [CODE_W-1:0] zone;
        logic              fired;
        int                step;
        fired = 1'b0;
        if (it.op == OP_UPDATE) begin
            // The state cascades until it settles; eight steps is a hard cap.
            for (step = 0; step < 8; step++) begin
                was = mode_now;
                case (mode_now)
                    CODE_NONE: begin
                        if (it.hash != hash_seen) enter_mode(CODE_NEW, it.hash, fired);
                    end
                    CODE_NEW: begin
                        enter_mode(CODE_FAR, it.hash, fired);
                    end
                    CODE_FAR, CODE_NEAR, CODE_IMMINENT: begin
                        zone = zone_of(it.metres);
                        if (zone != mode_now) enter_mode(zone, it.hash, fired);
                    end
                    CODE_AT: begin
                        if (it.metres > cfg_now.at_limit) enter_mode(CODE_NEW, it.hash, fired);
                    end
                    default: begin
                        mode_now = CODE_NONE;
                    end
                endcase
                if (was == mode_now) break;
            end
            hash_seen = it.hash;
        end else if (cue_left != '0) begin
            cue_left = cue_left - 16'd1;
            if (cue_left == '0) begin
                buzz_l = 1'b0;
                buzz_r = 1'b0;
            end
        end
        res.left    = buzz_l;
        res.right   = buzz_r;
        res.prox    = mode_now;
        res.started = fired;
    endtask

    function automatic void check_field(input string name, input logic [CODE_W-1:0] want_v,
                                        input logic [CODE_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s expected %0d got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: takes items from the pending queue, with random gaps.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feeder
        logic      hold;
        t_nav_item nxt;
        // An item not yet taken must stay on the bus unchanged.
        hold = s_axis_tvalid && !in_taken;
        if (!hold) begin
            if (feed_gap != 0) begin
                feed_gap = feed_gap - 1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                feed_gap = $urandom_range(0, 4);
            end else if (nav_pending.size() != 0) begin
                nxt = nav_pending.pop_front();
                s_axis_tuser <= nxt.op;
                s_axis_tdata <= {nxt.metres, nxt.hash};
                hold = 1'b1;
            end
        end
        s_axis_tvalid <= hold;
    end

    // Result side back-pressure, in random bursts.
    always @(negedge i_clk) begin : sink
        logic rdy;
        if (sink_gap != 0) begin
            sink_gap = sink_gap - 1;
            rdy = 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            sink_gap = $urandom_range(0, 4);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_axis_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input item and checks every
    // accepted result item against the oldest expectation. The input side
    // is handled first, so the order within the time step never matters.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : observe
        t_nav_item  seen;
        t_buzz_item want;
        t_buzz_item got;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen.op     = s_axis_tuser;
            seen.hash   = s_axis_tdata[31:0];
            seen.metres = s_axis_tdata[47:32];
            advance_controller(seen, want);
            buzz_expected.push_back(want);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.left    = m_axis_tdata[0];
            got.right   = m_axis_tdata[1];
            got.prox    = m_axis_tdata[4:2];
            got.started = m_axis_tdata[5];
            if (buzz_expected.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                fail_count++;
            end else begin
                want = buzz_expected.pop_front();
                check_field("left_on", want.left, got.left);
                check_field("right_on", want.right, got.right);
                check_field("prox_state", want.prox, got.prox);
                check_field("cue_started", want.started, got.started);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_item(input logic op, input logic [HASH_W-1:0] hash,
                              input logic [DIST_W-1:0] metres);
        t_nav_item it;
        it.op     = op;
        it.hash   = hash;
        it.metres = metres;
        nav_pending.push_back(it);
        queued_count++;
    endtask

    // Ticks carry random content in the unused fields so that every bit toggles.
    task automatic queue_ticks(input int n);
        repeat (n) queue_item(OP_TICK, $urandom(), DIST_W'($urandom_range(0, 65535)));
    endtask

    // Mostly icons with a cue pattern of their own, otherwise any hash.
    function automatic logic [HASH_W-1:0] pick_icon();
        case ($urandom_range(0, 7))
            0: return ICON_LEFT_ONLY;
            1: return ICON_ROUTE_TGT;
            2: return ICON_BOTH_A;
            3: return ICON_BOTH_B;
            4: return ICON_DEST;
            default: return $urandom();
        endcase
    endfunction

    // Distances on and beside the current thresholds, or anywhere in range.
    function automatic logic [DIST_W-1:0] edge_metres();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return cfg_now.at_limit;
            3: return cfg_now.at_limit + 16'd1;
            4: return cfg_now.imminent_limit - 16'd1;
            5: return cfg_now.imminent_limit;
            6: return cfg_now.near_limit - 16'd1;
            7: return cfg_now.near_limit;
            default: return DIST_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // A drive towards a turn: distances shrink from beyond the near threshold
    // down towards zero with ticks in between, then jump away again.
    task automatic queue_journey();
        logic [HASH_W-1:0] icon;
        int                metres;
        icon   = pick_icon();
        metres = int'(cfg_now.near_limit) + $urandom_range(0, cfg_now.near_limit / 2 + 8);
        if (metres > 65535) metres = 65535;
        repeat ($urandom_range(3, 8)) begin
            queue_item(OP_UPDATE, icon, DIST_W'(metres));
            queue_ticks($urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0) begin
                metres = 0;
            end else begin
                metres = metres - $urandom_range(0, metres / 2 + 1);
                if (metres < 0) metres = 0;
            end
        end
        queue_item(OP_UPDATE, icon, DIST_W'($urandom_range(cfg_now.near_limit, 65535)));
        // Now and then let a cue run out completely.
        if ($urandom_range(0, 4) == 0) queue_ticks($urandom_range(8, 20));
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_item(OP_UPDATE, ($urandom_range(0, 1) == 0) ? $urandom() : pick_icon(),
                           ($urandom_range(0, 1) == 0) ? edge_metres()
                                                       : DIST_W'($urandom_range(0, 65535)));
            end else begin
                queue_ticks(1);
            end
        end
    endtask

    task automatic run_random(input int quota);
        int first;
        first = queued_count;
        while (queued_count - first < quota) begin
            if ($urandom_range(0, 3) != 0) queue_journey();
            else queue_noise();
        end
    endtask

    // Waits until everything queued has been driven and every result checked.
    task automatic settle();
        do @(posedge i_clk);
        while (nav_pending.size() != 0 || s_axis_tvalid || buzz_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; the channel is left valid so that writes run back to back.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_AT_LIMIT:       cfg_now.at_limit       = val;
            CFG_IMMINENT_LIMIT: cfg_now.imminent_limit = val;
            CFG_NEAR_LIMIT:     cfg_now.near_limit     = val;
            CFG_SHORT_CUE:      cfg_now.short_cue_ms   = val;
            CFG_MEDIUM_CUE:     cfg_now.medium_cue_ms  = val;
            CFG_LONG_CUE:       cfg_now.long_cue_ms    = val;
            default: begin
                // Spare indexes change nothing.
            end
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] at_m, input logic [15:0] imm_m,
                                 input logic [15:0] near_m, input logic [15:0] short_ms,
                                 input logic [15:0] medium_ms, input logic [15:0] long_ms);
        reg_write(CFG_AT_LIMIT, at_m);
        reg_write(CFG_IMMINENT_LIMIT, imm_m);
        reg_write(CFG_NEAR_LIMIT, near_m);
        reg_write(CFG_SHORT_CUE, short_ms);
        reg_write(CFG_MEDIUM_CUE, medium_ms);
        reg_write(CFG_LONG_CUE, long_ms);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] at_r;
        logic [15:0] imm_r;
        cfg_now.at_limit       = RST_AT_LIMIT;
        cfg_now.imminent_limit = RST_IMMINENT_LIMIT;
        cfg_now.near_limit     = RST_NEAR_LIMIT;
        cfg_now.short_cue_ms   = RST_SHORT_CUE;
        cfg_now.medium_cue_ms  = RST_MEDIUM_CUE;
        cfg_now.long_cue_ms    = RST_LONG_CUE;
        mode_now  = CODE_NONE;
        hash_seen = '0;
        cue_left  = '0;
        buzz_l    = 1'b0;
        buzz_r    = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through the states with the reset thresholds.
        idle_pct = 20;
        queue_ticks(1);                                   // tick with no cue running
        queue_item(OP_UPDATE, 32'h0000_0000, 16'd0);      // same hash as reset: stays none
        queue_item(OP_UPDATE, ICON_LEFT_ONLY, 16'hFFFF);  // none, new turn, far
        queue_item(OP_UPDATE, ICON_LEFT_ONLY, 16'd100);   // on the near threshold: still far
        queue_item(OP_UPDATE, ICON_LEFT_ONLY, 16'd99);    // near, left-only cue
        queue_ticks(1);
        queue_item(OP_UPDATE, ICON_LEFT_ONLY, 16'd20);    // still near
        queue_item(OP_UPDATE, ICON_BOTH_A, 16'd19);       // imminent
        queue_item(OP_UPDATE, ICON_BOTH_A, 16'd11);
        queue_item(OP_UPDATE, ICON_BOTH_B, 16'd10);       // at, on the threshold
        queue_ticks(1);
        queue_item(OP_UPDATE, ICON_ROUTE_TGT, 16'd11);    // at, new turn, far, imminent
        queue_item(OP_UPDATE, ICON_DEST, 16'd0);          // at, long cue
        queue_item(OP_UPDATE, 32'hFFFF_FFFF, 16'hFFFF);   // leaves at, no cue
        queue_item(OP_UPDATE, 32'h5A5A_A5A5, 16'd50);     // silent cue for an unknown icon
        queue_ticks(1);
        queue_item(OP_UPDATE, ICON_LEFT_ONLY, 16'hFFFF);
        settle();

        // Zero cue length counts as one millisecond; spare indexes are ignored.
        reg_write(CFG_SPARE_LO, 16'hFFFF);
        reg_write(CFG_SPARE_HI, 16'h0000);
        apply_setting(16'd10, 16'd20, 16'd100, 16'd0, 16'd1, 16'd2);
        queue_item(OP_UPDATE, ICON_LEFT_ONLY, 16'd5);
        queue_ticks(2);                                   // cue ends, then nothing happens
        queue_item(OP_UPDATE, ICON_DEST, 16'hFFFF);
        queue_item(OP_UPDATE, ICON_DEST, 16'd0);
        queue_ticks(3);
        settle();

        // Random phases over several register settings.
        idle_pct = 12 * $urandom_range(0, 2);
        apply_setting(16'd10, 16'd20, 16'd100, 16'd3, 16'd5, 16'd7);
        run_random(110);
        settle();

        // Extremes: only zero is at, almost everything else is imminent.
        idle_pct = 12 * $urandom_range(0, 2);
        apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd2, 16'hFFFF);
        run_random(90);
        settle();

        // Thresholds in the wrong order: the at test has priority.
        idle_pct = 12 * $urandom_range(0, 2);
        apply_setting(16'd300, 16'd50, 16'd20, 16'd2, 16'd0, 16'd6);
        run_random(90);
        settle();

        idle_pct = 12 * $urandom_range(0, 2);
        at_r  = 16'($urandom_range(0, 200));
        imm_r = at_r + 16'($urandom_range(0, 300));
        apply_setting(at_r, imm_r, imm_r + 16'($urandom_range(0, 3000)),
                      16'($urandom_range(1, 9)), 16'($urandom_range(1, 9)),
                      16'($urandom_range(1, 9)));
        run_random(100);
        settle();

        // Every distance counts as reached, so the state sticks at at.
        idle_pct = 12 * $urandom_range(0, 2);
        apply_setting(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd4, 16'd0);
        run_random(50);
        settle();

        // Closing stretch at full rate on both sides.
        idle_pct = 0;
        apply_setting(16'd10, 16'd20, 16'd100, 16'd4, 16'd8, 16'd12);
        run_random(100);
        settle();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
